@@ src/phc_pkg.sv @@
// Shared types, register codes and constants for the pump hysteresis controller.
`timescale 1ns / 1ps

package phc_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_SAMPLE  = 3'd1,
    ACT_MAN_ON  = 3'd2,
    ACT_MAN_OFF = 3'd3,
    ACT_EMERG   = 3'd4,
    ACT_RELEASE = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    REG_LOW_THR   = 3'd0,
    REG_HIGH_THR  = 3'd1,
    REG_MIN_OFF   = 3'd2,
    REG_MAX_RUN   = 3'd3,
    REG_DEC_PER   = 3'd4,
    REG_DAILY_LIM = 3'd5
  } reg_e;

  localparam int unsigned ADDR_W = 5;

  localparam logic [31:0] DAY_MS        = 32'd86400000;
  localparam logic [31:0] MS_PER_S      = 32'd1000;
  localparam logic [5:0]  DAY_COUNT_MAX = 6'd63;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x.
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned PROD_W      = 32 + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h10624DD3;

  localparam logic [9:0]  LOW_THR_RST   = 10'd300;
  localparam logic [9:0]  HIGH_THR_RST  = 10'd700;
  localparam logic [31:0] MIN_OFF_RST   = 32'd300000;
  localparam logic [31:0] MAX_RUN_RST   = 32'd600000;
  localparam logic [31:0] DEC_PER_RST   = 32'd5000;
  localparam logic [5:0]  DAILY_LIM_RST = 6'd50;

  typedef struct packed {
    logic [9:0]  low_threshold;
    logic [9:0]  high_threshold;
    logic [31:0] min_off_interval;
    logic [31:0] max_run_time;
    logic [31:0] decision_period;
    logic [5:0]  daily_limit;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] now_ms;
    logic        hw_safe;
    logic [9:0]  humidity;
    logic [31:0] run_duration;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       pump_on;
    logic       emergency_latched;
    logic       manual_active;
    logic [5:0] activations_today;
  } res_t;

  typedef struct packed {
    logic        accrue;
    logic [31:0] diff;
  } accr_t;

endpackage

@@ src/phc_cfg.sv @@
// APB register file holding the controller thresholds and timing limits.
`timescale 1ns / 1ps

module phc_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [phc_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output logic                       pready_o,
  output phc_pkg::cfg_t              cfg_o
);

  phc_pkg::cfg_t cfg_q;
  phc_pkg::reg_e idx;
  logic          wr_en;

  assign idx      = phc_pkg::reg_e'(paddr_i[4:2]);
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_threshold    <= phc_pkg::LOW_THR_RST;
      cfg_q.high_threshold   <= phc_pkg::HIGH_THR_RST;
      cfg_q.min_off_interval <= phc_pkg::MIN_OFF_RST;
      cfg_q.max_run_time     <= phc_pkg::MAX_RUN_RST;
      cfg_q.decision_period  <= phc_pkg::DEC_PER_RST;
      cfg_q.daily_limit      <= phc_pkg::DAILY_LIM_RST;
    end else if (wr_en) begin
      case (idx)
        phc_pkg::REG_LOW_THR:   cfg_q.low_threshold    <= pwdata_i[9:0];
        phc_pkg::REG_HIGH_THR:  cfg_q.high_threshold   <= pwdata_i[9:0];
        phc_pkg::REG_MIN_OFF:   cfg_q.min_off_interval <= pwdata_i;
        phc_pkg::REG_MAX_RUN:   cfg_q.max_run_time     <= pwdata_i;
        phc_pkg::REG_DEC_PER:   cfg_q.decision_period  <= pwdata_i;
        phc_pkg::REG_DAILY_LIM: cfg_q.daily_limit      <= pwdata_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      phc_pkg::REG_LOW_THR:   prdata_o = {22'd0, cfg_q.low_threshold};
      phc_pkg::REG_HIGH_THR:  prdata_o = {22'd0, cfg_q.high_threshold};
      phc_pkg::REG_MIN_OFF:   prdata_o = cfg_q.min_off_interval;
      phc_pkg::REG_MAX_RUN:   prdata_o = cfg_q.max_run_time;
      phc_pkg::REG_DEC_PER:   prdata_o = cfg_q.decision_period;
      phc_pkg::REG_DAILY_LIM: prdata_o = {26'd0, cfg_q.daily_limit};
      default:                prdata_o = '0;
    endcase
  end

endmodule

@@ src/phc_ctrl.sv @@
// Pump state machine: timers, hysteresis decision, safety and emergency handling.
`timescale 1ns / 1ps

module phc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  phc_pkg::item_t item_i,
  input  phc_pkg::cfg_t  cfg_i,
  output phc_pkg::res_t  res_o,
  output phc_pkg::accr_t accr_o
);

  logic        running_q, running_d;
  logic        emerg_q, emerg_d;
  logic        manual_q, manual_d;
  logic [31:0] last_dec_q, last_dec_d;
  logic [31:0] last_stop_q, last_stop_d;
  logic [31:0] start_q, start_d;
  logic [31:0] deadline_q, deadline_d;
  logic [31:0] last_acc_q, last_acc_d;
  logic [31:0] last_day_q, last_day_d;
  logic [5:0]  day_q, day_d;

  logic        acc;
  logic        accrue;
  logic [31:0] diff_acc;
  logic [31:0] since_stop;
  logic [31:0] since_dec;
  logic [31:0] since_start;
  logic [31:0] since_day;
  logic        safe_now;
  logic        start_ok;
  logic [31:0] dur_sel;
  logic [31:0] dur_c;
  logic [31:0] deadline_new;
  logic [5:0]  day_inc;
  logic [5:0]  day_after;
  logic [31:0] now;

  always_comb begin
    running_d   = running_q;
    emerg_d     = emerg_q;
    manual_d    = manual_q;
    last_dec_d  = last_dec_q;
    last_stop_d = last_stop_q;
    start_d     = start_q;
    deadline_d  = deadline_q;
    last_acc_d  = last_acc_q;
    last_day_d  = last_day_q;
    day_d       = day_q;
    acc         = 1'b0;
    accrue      = 1'b0;
    day_after   = day_q;

    now          = item_i.now_ms;
    diff_acc     = now - last_acc_q;
    since_stop   = now - last_stop_q;
    since_dec    = now - last_dec_q;
    since_start  = now - start_q;
    since_day    = now - last_day_q;
    safe_now     = !emerg_q && item_i.hw_safe && (day_q <= cfg_i.daily_limit);
    start_ok     = safe_now && !running_q;
    dur_sel      = (item_i.action == phc_pkg::ACT_MAN_ON) ? item_i.run_duration
                                                          : cfg_i.max_run_time;
    dur_c        = (dur_sel > cfg_i.max_run_time) ? cfg_i.max_run_time : dur_sel;
    deadline_new = (dur_c != 32'd0) ? now + dur_c : 32'd0;
    day_inc      = (day_q < phc_pkg::DAY_COUNT_MAX) ? day_q + 6'd1 : day_q;

    if (en_i) begin
      case (item_i.action)
        phc_pkg::ACT_TICK: begin
          if (running_q) begin
            if (diff_acc >= phc_pkg::MS_PER_S) begin
              accrue     = 1'b1;
              last_acc_d = now;
            end
            if (((deadline_q != 32'd0) && (now >= deadline_q)) ||
                (since_start >= cfg_i.max_run_time)) begin
              running_d   = 1'b0;
              last_stop_d = now;
              manual_d    = 1'b0;
              deadline_d  = 32'd0;
              acc         = 1'b1;
            end
          end
          if (since_day > phc_pkg::DAY_MS) begin
            day_after  = 6'd0;
            day_d      = 6'd0;
            last_day_d = now;
          end
          if (running_d &&
              !(!emerg_q && item_i.hw_safe && (day_after <= cfg_i.daily_limit))) begin
            running_d   = 1'b0;
            last_stop_d = now;
            manual_d    = 1'b0;
            deadline_d  = 32'd0;
            acc         = 1'b1;
          end
        end
        phc_pkg::ACT_SAMPLE: begin
          if (!emerg_q && !manual_q && (since_dec >= cfg_i.decision_period)) begin
            last_dec_d = now;
            if (!running_q) begin
              if ((item_i.humidity < cfg_i.low_threshold) &&
                  (since_stop >= cfg_i.min_off_interval) && start_ok) begin
                running_d  = 1'b1;
                start_d    = now;
                manual_d   = 1'b0;
                day_d      = day_inc;
                deadline_d = deadline_new;
                acc        = 1'b1;
              end
            end else if (item_i.humidity >= cfg_i.high_threshold) begin
              running_d   = 1'b0;
              last_stop_d = now;
              manual_d    = 1'b0;
              deadline_d  = 32'd0;
              acc         = 1'b1;
            end
          end
        end
        phc_pkg::ACT_MAN_ON: begin
          if (start_ok) begin
            running_d  = 1'b1;
            start_d    = now;
            manual_d   = 1'b1;
            day_d      = day_inc;
            deadline_d = deadline_new;
            acc        = 1'b1;
          end
        end
        phc_pkg::ACT_MAN_OFF: begin
          if (running_q) begin
            running_d   = 1'b0;
            last_stop_d = now;
            manual_d    = 1'b0;
            deadline_d  = 32'd0;
            acc         = 1'b1;
          end
        end
        phc_pkg::ACT_EMERG: begin
          running_d  = 1'b0;
          emerg_d    = 1'b1;
          manual_d   = 1'b0;
          deadline_d = 32'd0;
          acc        = 1'b1;
        end
        phc_pkg::ACT_RELEASE: begin
          if (!emerg_q) begin
            acc = 1'b1;
          end else if (item_i.hw_safe) begin
            emerg_d = 1'b0;
            acc     = 1'b1;
          end
        end
        default: ;
      endcase
    end

    res_o.accepted          = acc;
    res_o.pump_on           = running_d;
    res_o.emergency_latched = emerg_d;
    res_o.manual_active     = manual_d;
    res_o.activations_today = day_d;
    accr_o.accrue           = accrue;
    accr_o.diff             = diff_acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      emerg_q     <= 1'b0;
      manual_q    <= 1'b0;
      last_dec_q  <= 32'd0;
      last_stop_q <= 32'd0;
      start_q     <= 32'd0;
      deadline_q  <= 32'd0;
      last_acc_q  <= 32'd0;
      last_day_q  <= 32'd0;
      day_q       <= 6'd0;
    end else begin
      running_q   <= running_d;
      emerg_q     <= emerg_d;
      manual_q    <= manual_d;
      last_dec_q  <= last_dec_d;
      last_stop_q <= last_stop_d;
      start_q     <= start_d;
      deadline_q  <= deadline_d;
      last_acc_q  <= last_acc_d;
      last_day_q  <= last_day_d;
      day_q       <= day_d;
    end
  end

endmodule

@@ src/phc_rt.sv @@
// Runtime accumulator: converts elapsed milliseconds to seconds and sums them.
`timescale 1ns / 1ps

module phc_rt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load2_i,
  input  logic           load3_i,
  input  logic           valid1_i,
  input  logic           valid2_i,
  input  phc_pkg::accr_t accr1_i,
  output logic [31:0]    runtime_seconds_o
);

  logic                       accr2_q;
  logic [phc_pkg::PROD_W-1:0] prod_q;
  logic [phc_pkg::PROD_W-1:0] prod_d;
  logic [31:0]                total_q;
  logic [31:0]                secs;

  assign prod_d = phc_pkg::PROD_W'(accr1_i.diff) * phc_pkg::PROD_W'(phc_pkg::RECIP_1000);
  assign secs   = 32'(prod_q[phc_pkg::PROD_W-1:phc_pkg::RECIP_SHIFT]);
  assign runtime_seconds_o = total_q;

  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accr2_q <= 1'b0;
      total_q <= 32'd0;
    end else begin
      if (load2_i) begin
        accr2_q <= valid1_i && accr1_i.accrue;
      end
      if (load3_i && valid2_i && accr2_q) begin
        total_q <= total_q + secs;
      end
    end
  end

endmodule

@@ src/pump_hysteresis_controller_top.sv @@
// Top level of the pump hysteresis controller with stream ports and APB config.
//   channel  | direction | handshake                  | contents
//   s_axis   | in        | s_axis_tvalid/tready       | one action word
//   m_axis   | out       | m_axis_tvalid/tready       | one result word per action
//   apb      | in/out    | psel, penable, pready      | six config registers
// One word is accepted per cycle while the output is not stalled; each word passes
// the four-register path input, state, multiplier, sum.
// The runtime divide by 1000 is a reciprocal multiply with its own register stage.
// Reset is asynchronous and active low and needs no clearing pass.
// A stalled output holds its word; input is taken while any stage is free.
`timescale 1ns / 1ps

module pump_hysteresis_controller_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // now_ms[31:0], hw_safe[32], humidity[42:33], run_duration[74:43], zeros
  input  logic [79:0]                s_axis_tdata_i,
  // action[2:0]
  input  logic [2:0]                 s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // accepted[0], pump_on[1], emergency_latched[2], manual_active[3],
  // activations_today[9:4], runtime_seconds[41:10], zeros
  output logic [47:0]                m_axis_tdata_o,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [phc_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  output logic [31:0]                prdata_o,
  output logic                       pready_o
);

  phc_pkg::cfg_t  cfg;
  phc_pkg::item_t in0_q;
  phc_pkg::res_t  res_ctrl;
  phc_pkg::res_t  res1_q, res2_q, res3_q;
  phc_pkg::accr_t accr_ctrl;
  phc_pkg::accr_t accr1_q;
  logic           v0_q, v1_q, v2_q, v3_q;
  logic           en0, en1, en2, en3;
  logic [31:0]    runtime;

  assign en3 = !v3_q || m_axis_tready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign s_axis_tready_o = en0;
  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {6'd0, runtime, res3_q.activations_today,
                            res3_q.manual_active, res3_q.emergency_latched,
                            res3_q.pump_on, res3_q.accepted};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      in0_q.action       <= phc_pkg::action_e'(s_axis_tuser_i);
      in0_q.now_ms       <= s_axis_tdata_i[31:0];
      in0_q.hw_safe      <= s_axis_tdata_i[32];
      in0_q.humidity     <= s_axis_tdata_i[42:33];
      in0_q.run_duration <= s_axis_tdata_i[74:43];
    end
    if (en1) begin
      res1_q  <= res_ctrl;
      accr1_q <= accr_ctrl;
    end
    if (en2) res2_q <= res1_q;
    if (en3) res3_q <= res2_q;
  end

  phc_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .cfg_o     (cfg)
  );

  phc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (v0_q && en1),
    .item_i (in0_q),
    .cfg_i  (cfg),
    .res_o  (res_ctrl),
    .accr_o (accr_ctrl)
  );

  phc_rt u_rt (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load2_i           (en2),
    .load3_i           (en3),
    .valid1_i          (v1_q),
    .valid2_i          (v2_q),
    .accr1_i           (accr1_q),
    .runtime_seconds_o (runtime)
  );

endmodule

@@ src/phc_checker.sv @@
// Port-level checks for the pump hysteresis controller and their bind.
`timescale 1ns / 1ps

module phc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result word changed.");

  a_no_run_in_emerg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[1] && m_axis_tdata_o[2]))
    else $error("Pump reported running while emergency is latched.");

  a_manual_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[3] |-> m_axis_tdata_o[1])
    else $error("Manual flag set while pump is off.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input stalled while the output is empty.");

endmodule

bind pump_hysteresis_controller_top phc_checker u_phc_checker (.*);
